// File: hw/rtl/tvlc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and the sine table entry function of the two-voice chorus.
package tvlc_pkg;

    localparam int DELAY_DEPTH  = 1024;
    localparam int ADDR_BITS    = $clog2(DELAY_DEPTH);
    localparam int FILL_BITS    = ADDR_BITS + 1;
    localparam int RING_ENTRIES = 2 * DELAY_DEPTH;
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);

    localparam int SAMPLE_W   = 16;
    localparam int SINE_W     = 17;
    localparam int MIX_W      = 17;
    localparam int STEP_W     = 32;
    localparam int BASE_W     = 10;
    localparam int DEPTH_W    = 7;
    localparam int OFF_W      = 8;
    localparam int PROD_W     = DEPTH_W + 1 + SINE_W;
    localparam int LEN_W      = (ADDR_BITS + 2 > 12) ? ADDR_BITS + 2 : 12;
    localparam int TERM_W     = MIX_W + 1 + SAMPLE_W;
    localparam int ACC_W      = TERM_W + 2;
    localparam int Q_W        = ACC_W - 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [MIX_W-1:0]  MIX_ONE     = MIX_W'(65536);
    localparam logic [BASE_W-1:0] BASE_A_RST  = BASE_W'(480);
    localparam logic [BASE_W-1:0] BASE_B_RST  = BASE_W'(720);
    localparam logic [DEPTH_W-1:0] DEPTH_RST  = DEPTH_W'(50);
    localparam logic [STEP_W-1:0] STEP_A_RST  = STEP_W'(134218);
    localparam logic [STEP_W-1:0] STEP_B_RST  = STEP_W'(161061);
    localparam logic [MIX_W-1:0]  MIX_RST     = MIX_W'(32768);

    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_A  = 3'd0,
        CFG_BASE_B  = 3'd1,
        CFG_DEPTH_A = 3'd2,
        CFG_DEPTH_B = 3'd3,
        CFG_STEP_A  = 3'd4,
        CFG_STEP_B  = 3'd5,
        CFG_WET_MIX = 3'd6
    } t_cfg_idx;

    // Q2.30 quarter-wave Taylor series (to x^9), rounded to Q1.15.
    // Evaluated at elaboration only, one call per table entry.
    function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned k);
        logic [63:0] turn;
        logic [63:0] f;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q15;
        logic [1:0]  quad;
        turn = 64'(k) << (32 - SINE_BITS);
        quad = turn[31:30];
        f    = {34'd0, turn[29:0]};
        if (quad[0]) begin
            f = ONE_Q30 - f;
        end
        a  = (f * HALF_PI_Q30) >> 30;
        a2 = (a * a) >> 30;
        t  = ONE_Q30 - a2 / 64'd72;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 64'd6;
        s  = (a * t) >> 30;
        if (s > ONE_Q30) begin
            s = ONE_Q30;
        end
        q15 = (s * 64'd32768 + (ONE_Q30 >> 1)) >> 30;
        if (q15 > 64'd32768) begin
            q15 = 64'd32768;
        end
        if (quad[1]) begin
            sine_entry = -$signed(SINE_W'(q15));
        end else begin
            sine_entry = $signed(SINE_W'(q15));
        end
    endfunction

endpackage

// File: hw/rtl/two_voice_lfo_chorus.sv
`timescale 1ns / 1ps
// Two-voice chorus: sine-LFO modulated delay rings in one RAM, dry/wet mix pipeline.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------
//  input    | i_valid / o_stall   | i_op, i_dry_sample
//  output   | o_valid / i_stall   | o_mixed_sample
//  config   | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// An accepted request moves through the stage 1, 2, 3 and 4 registers into the output register.
// Requests that alternate voices go in every cycle unless a stall holds them; a voice's next
// request waits for the ring index update (sine ROM read, offset, length compare) of its last.
// Reset clears control state only; per-voice fill counts make ring entries never
// written since reset read as zero, so there is no clearing pass.
// Output stall backs up through the stages; bubbles are squeezed out first.
module two_voice_lfo_chorus
    import tvlc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_op,
    input  logic signed [SAMPLE_W-1:0] i_dry_sample,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_mixed_sample,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    // configuration
    logic [BASE_W-1:0]  r_base_a;
    logic [BASE_W-1:0]  r_base_b;
    logic [DEPTH_W-1:0] r_depth_a;
    logic [DEPTH_W-1:0] r_depth_b;
    logic [STEP_W-1:0]  r_step_a;
    logic [STEP_W-1:0]  r_step_b;
    logic [MIX_W-1:0]   r_wet_mix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_a  <= BASE_A_RST;
            r_base_b  <= BASE_B_RST;
            r_depth_a <= DEPTH_RST;
            r_depth_b <= DEPTH_RST;
            r_step_a  <= STEP_A_RST;
            r_step_b  <= STEP_B_RST;
            r_wet_mix <= MIX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BASE_A:  r_base_a  <= i_cfg_data[BASE_W-1:0];
                CFG_BASE_B:  r_base_b  <= i_cfg_data[BASE_W-1:0];
                CFG_DEPTH_A: r_depth_a <= i_cfg_data[DEPTH_W-1:0];
                CFG_DEPTH_B: r_depth_b <= i_cfg_data[DEPTH_W-1:0];
                CFG_STEP_A:  r_step_a  <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_B:  r_step_b  <= i_cfg_data[STEP_W-1:0];
                CFG_WET_MIX: r_wet_mix <= i_cfg_data[MIX_W-1:0];
                default: ;
            endcase
        end
    end

    logic [MIX_W-1:0] mix_eff;
    logic [MIX_W-1:0] mix_inv;
    assign mix_eff = (r_wet_mix > MIX_ONE) ? MIX_ONE : r_wet_mix;
    assign mix_inv = MIX_ONE - mix_eff;

    // per-voice state
    logic [ADDR_BITS-1:0] r_pos_a;
    logic [ADDR_BITS-1:0] r_pos_b;
    logic [STEP_W-1:0]    r_phase_a;
    logic [STEP_W-1:0]    r_phase_b;
    logic [FILL_BITS-1:0] r_fill_a;
    logic [FILL_BITS-1:0] r_fill_b;

    // pipeline registers
    logic                       r_v1;
    logic                       r_s1_op;
    logic signed [SAMPLE_W-1:0] r_s1_dry;
    logic [ADDR_BITS-1:0]       r_s1_pos;
    logic signed [SINE_W-1:0]   r_s1_sine;

    logic                       r_v2;
    logic                       r_s2_op;
    logic signed [SAMPLE_W-1:0] r_s2_dry;
    logic [ADDR_BITS-1:0]       r_s2_pos;
    logic signed [OFF_W-1:0]    r_s2_off;

    logic                       r_v3;
    logic signed [TERM_W-1:0]   r_s3_dry_term;
    logic                       r_s3_hit;
    logic signed [SAMPLE_W-1:0] r_rd_data;

    logic                       r_v4;
    logic signed [TERM_W-1:0]   r_s4_dry_term;
    logic signed [TERM_W-1:0]   r_s4_wet;

    logic                       r_o_valid;
    logic signed [SAMPLE_W-1:0] r_o_sample;

    // flow control
    logic rdy_o, rdy4, rdy3, rdy2, rdy1;
    logic mv4, mv3, mv2, mv1;
    logic hazard, acc_in;

    assign rdy_o = !r_o_valid || !i_stall;
    assign mv4   = r_v4 && rdy_o;
    assign rdy4  = !r_v4 || rdy_o;
    assign mv3   = r_v3 && rdy4;
    assign rdy3  = !r_v3 || rdy4;
    assign mv2   = r_v2 && rdy3;
    assign rdy2  = !r_v2 || rdy3;
    assign mv1   = r_v1 && rdy2;
    assign rdy1  = !r_v1 || rdy2;

    // same voice may not enter while its index update is still open
    assign hazard  = (r_v1 && (r_s1_op == i_op)) || (r_v2 && (r_s2_op == i_op) && !mv2);
    assign o_stall = !rdy1 || hazard;
    assign acc_in  = i_valid && !o_stall;

    // stage 2 index update, also forwarded to the entry side
    logic [BASE_W-1:0]          s2_base;
    logic [FILL_BITS-1:0]       s2_fill;
    logic signed [LEN_W-1:0]    s2_len;
    logic signed [LEN_W-1:0]    s2_len_c;
    logic [FILL_BITS-1:0]       s2_p1;
    logic [ADDR_BITS-1:0]       s2_np;
    logic                       s2_hit;
    logic signed [TERM_W-1:0]   s2_dry_term;

    assign s2_base  = r_s2_op ? r_base_b : r_base_a;
    assign s2_fill  = r_s2_op ? r_fill_b : r_fill_a;
    assign s2_len   = LEN_W'($signed({1'b0, s2_base})) + LEN_W'(r_s2_off);
    assign s2_len_c = (s2_len < LEN_W'(1)) ? LEN_W'(1)
                    : ((s2_len > LEN_W'(DELAY_DEPTH)) ? LEN_W'(DELAY_DEPTH) : s2_len);
    assign s2_p1    = FILL_BITS'(r_s2_pos) + FILL_BITS'(1);
    assign s2_np    = ($signed(LEN_W'(s2_p1)) >= s2_len_c) ? '0 : s2_p1[ADDR_BITS-1:0];
    assign s2_hit   = FILL_BITS'(s2_np) < s2_fill;
    assign s2_dry_term = $signed({1'b0, mix_inv}) * r_s2_dry;

    // entry side
    logic [ADDR_BITS-1:0] in_pos;
    logic [STEP_W-1:0]    in_phase;
    logic [FILL_BITS-1:0] in_fill;
    logic [SINE_BITS-1:0] sine_idx;

    assign in_pos   = (r_v2 && (r_s2_op == i_op)) ? s2_np : (i_op ? r_pos_b : r_pos_a);
    assign in_phase = i_op ? r_phase_b : r_phase_a;
    assign in_fill  = i_op ? r_fill_b : r_fill_a;
    assign sine_idx = in_phase[STEP_W-1 -: SINE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_a   <= '0;
            r_pos_b   <= '0;
            r_phase_a <= '0;
            r_phase_b <= '0;
            r_fill_a  <= '0;
            r_fill_b  <= '0;
        end else begin
            if (acc_in) begin
                if (i_op) begin
                    r_phase_b <= r_phase_b + r_step_b;
                    if (FILL_BITS'(in_pos) == in_fill) begin
                        r_fill_b <= in_fill + FILL_BITS'(1);
                    end
                end else begin
                    r_phase_a <= r_phase_a + r_step_a;
                    if (FILL_BITS'(in_pos) == in_fill) begin
                        r_fill_a <= in_fill + FILL_BITS'(1);
                    end
                end
            end
            if (mv2) begin
                if (r_s2_op) begin
                    r_pos_b <= s2_np;
                end else begin
                    r_pos_a <= s2_np;
                end
            end
        end
    end

    // sine ROM, registered read
    logic signed [SINE_W-1:0] sine_tab [SINE_ENTRIES];

    for (genvar gk = 0; gk < SINE_ENTRIES; gk++) begin : g_sine
        assign sine_tab[gk] = sine_entry(gk);
    end

    // both rings in one RAM, voice select as the top address bit
    logic [SAMPLE_W-1:0] r_ring [RING_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_ring[{i_op, in_pos}] <= i_dry_sample;
        end
        // old data on a same-address write keeps request order
        if (mv2) begin
            r_rd_data <= $signed(r_ring[{r_s2_op, s2_np}]);
        end
    end

    // stage 1: LFO offset, truncated toward zero
    logic [DEPTH_W-1:0]       s1_depth;
    logic signed [PROD_W-1:0] s1_prod;
    logic [PROD_W-1:0]        s1_mag;
    logic [OFF_W-1:0]         s1_off_mag;
    logic signed [OFF_W-1:0]  s1_off;

    assign s1_depth   = r_s1_op ? r_depth_b : r_depth_a;
    assign s1_prod    = $signed({1'b0, s1_depth}) * r_s1_sine;
    assign s1_mag     = s1_prod[PROD_W-1] ? PROD_W'(-s1_prod) : PROD_W'(s1_prod);
    assign s1_off_mag = OFF_W'(s1_mag >> 15);
    assign s1_off     = s1_prod[PROD_W-1] ? -$signed(s1_off_mag) : $signed(s1_off_mag);

    // stage 3: wet term
    logic signed [SAMPLE_W-1:0] s3_delayed;
    logic signed [TERM_W-1:0]   s3_wet;

    assign s3_delayed = r_s3_hit ? r_rd_data : '0;
    assign s3_wet     = $signed({1'b0, mix_eff}) * s3_delayed;

    // stage 4: sum, round half up, saturate
    logic signed [ACC_W-1:0]    s4_acc;
    logic signed [Q_W-1:0]      s4_q;
    logic signed [SAMPLE_W-1:0] s4_sat;

    assign s4_acc = (ACC_W'(r_s4_dry_term) <<< 1) + ACC_W'(r_s4_wet) + ACC_W'(65536);
    assign s4_q   = Q_W'(s4_acc >>> 17);
    assign s4_sat = (s4_q > Q_W'(32767))  ? SAMPLE_W'(32767)
                  : ((s4_q < -Q_W'(32768)) ? SAMPLE_W'(-32768) : SAMPLE_W'(s4_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (acc_in) begin
                r_v1 <= 1'b1;
            end else if (mv1) begin
                r_v1 <= 1'b0;
            end
            if (mv1) begin
                r_v2 <= 1'b1;
            end else if (mv2) begin
                r_v2 <= 1'b0;
            end
            if (mv2) begin
                r_v3 <= 1'b1;
            end else if (mv3) begin
                r_v3 <= 1'b0;
            end
            if (mv3) begin
                r_v4 <= 1'b1;
            end else if (mv4) begin
                r_v4 <= 1'b0;
            end
            if (mv4) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_s1_op   <= i_op;
            r_s1_dry  <= i_dry_sample;
            r_s1_pos  <= in_pos;
            r_s1_sine <= sine_tab[sine_idx];
        end
        if (mv1) begin
            r_s2_op  <= r_s1_op;
            r_s2_dry <= r_s1_dry;
            r_s2_pos <= r_s1_pos;
            r_s2_off <= s1_off;
        end
        if (mv2) begin
            r_s3_dry_term <= s2_dry_term;
            r_s3_hit      <= s2_hit;
        end
        if (mv3) begin
            r_s4_dry_term <= r_s3_dry_term;
            r_s4_wet      <= s3_wet;
        end
        if (mv4) begin
            r_o_sample <= s4_sat;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_mixed_sample = r_o_sample;

    // checks
    a_pos_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FILL_BITS'(r_pos_a) <= r_fill_a) && (FILL_BITS'(r_pos_b) <= r_fill_b))
        else $error("ring index beyond written region");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill_a <= FILL_BITS'(DELAY_DEPTH)) && (r_fill_b <= FILL_BITS'(DELAY_DEPTH)))
        else $error("fill count beyond ring depth");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> (r_v1 && (r_s1_op == $past(i_op))))
        else $error("accepted request not in stage 1");

    a_pos_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mv2 && !r_s2_op) |=> (r_pos_a == $past(s2_np)))
        else $error("voice A index not committed");

endmodule
